@@ hw/rtl/lara_pkg.sv @@
// Shared types, codes and constants of the request admission unit.
package lara_pkg;

    localparam int unsigned MODE_W   = 3;
    localparam int unsigned TAG_W    = 16;
    localparam int unsigned SLOT_W   = 4;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned RES_W    = 6;

    localparam logic [RES_W-1:0] MAX_RESULTS = 6'd32;
    localparam logic [31:0] MIN_SEEN_RESET = 32'd1000000;
    localparam logic [31:0] USEC_PER_SEC   = 32'd1000000;

    localparam logic [MODE_W-1:0] MODE_REQUEST     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REPLY       = 3'd1;
    localparam logic [MODE_W-1:0] MODE_UNDELIVERED = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DISCONNECT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TICK        = 3'd4;

    localparam logic [2:0] ACT_ISSUE        = 3'd0;
    localparam logic [2:0] ACT_REPLY        = 3'd1;
    localparam logic [2:0] ACT_UNDELIVERED  = 3'd2;
    localparam logic [2:0] ACT_DISCONNECTED = 3'd3;
    localparam logic [2:0] ACT_DROPPED      = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_IN_FLY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_IN_FLY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RATE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TRACKED  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LAT_FACTOR   = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [TAG_W-1:0]  request_tag;
        logic [SLOT_W-1:0] slot;
        logic              track_delivery;
        logic              session_notify;
    } in_word_t;

    typedef struct packed {
        logic [2:0]        action;
        logic [TAG_W-1:0]  request_tag_res;
        logic [SLOT_W-1:0] slot_out;
        logic              last;
    } out_word_t;

    typedef struct packed {
        logic [4:0]  min_in_fly;
        logic [4:0]  max_in_fly;
        logic [23:0] target_rate;
        logic [31:0] min_tracked_latency;
        logic [15:0] latency_factor;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADMIT,
        ST_RPL,
        ST_TRIM,
        ST_PUMP,
        ST_PWAIT,
        ST_DW_RD,
        ST_DW,
        ST_DP_RD,
        ST_DP,
        ST_CLEAR,
        ST_FIN
    } state_t;

endpackage

@@ hw/rtl/latency_adaptive_request_admission_unit.sv @@
// Request admission unit: in-flight window and pending FIFO held in registered-read RAMs.
// A request's result word is staged in ST_ADMIT and offered from ST_FIN.
// One input word at a time; ticks and ignored words end in ST_IDLE, out stall delays others.
// Reply: ST_RPL, ST_TRIM per trimmed entry, ST_PUMP and ST_PWAIT per drained request.
// Disconnect: ST_DW_RD+ST_DW per window entry, ST_DP_RD+ST_DP per pending one, ST_CLEAR.
// Reset: flags and pointers cleared, window and FIFO empty, minimum latency 1000000 us.
module latency_adaptive_request_admission_unit #(
    parameter int unsigned WINDOW_DEPTH  = 16,
    parameter int unsigned PENDING_DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  lara_pkg::in_word_t                       in_word,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output lara_pkg::out_word_t                      out_word,
    input  logic                                     cfg_we,
    input  logic [lara_pkg::CFG_IDX_W-1:0]           cfg_idx,
    input  logic [lara_pkg::CFG_DATA_W-1:0]          cfg_data
);

    import lara_pkg::*;

    localparam int unsigned TAG_WIDTH = TAG_W;
    localparam int unsigned WIDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int unsigned WCNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned WSUM_W = WCNT_W + 1;
    localparam int unsigned PIDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int unsigned PCNT_W = $clog2(PENDING_DEPTH + 1);
    localparam int unsigned PSUM_W = PCNT_W + 1;
    localparam int unsigned WRAM_W = TAG_WIDTH + 33;
    localparam int unsigned PRAM_W = TAG_WIDTH + 2;

    state_t               state_reg, state_next;
    cfg_t                 cfg_reg, cfg_next;
    logic [WINDOW_DEPTH-1:0] live_reg, live_next;
    logic [WINDOW_DEPTH-1:0] done_reg, done_next;
    logic [WIDX_W-1:0]    win_head_reg, win_head_next;
    logic [WCNT_W-1:0]    win_count_reg, win_count_next;
    logic [PIDX_W-1:0]    pend_head_reg, pend_head_next;
    logic [PCNT_W-1:0]    pend_count_reg, pend_count_next;
    logic [31:0]          min_seen_reg, min_seen_next;
    logic [31:0]          now_reg, now_next;
    logic [RES_W-1:0]     res_n_reg, res_n_next;
    logic                 hold_valid_reg, hold_valid_next;
    out_word_t            hold_word_reg, hold_word_next;
    logic                 out_valid_reg, out_valid_next;
    out_word_t            out_word_reg, out_word_next;
    in_word_t             in_reg, in_next;
    logic [WIDX_W-1:0]    walk_w_idx_reg, walk_w_idx_next;
    logic [WCNT_W-1:0]    walk_w_left_reg, walk_w_left_next;
    logic [PIDX_W-1:0]    walk_p_idx_reg, walk_p_idx_next;
    logic [PCNT_W-1:0]    walk_p_left_reg, walk_p_left_next;

    logic                 in_acc;
    logic                 out_free;
    logic                 res_full;
    logic                 emit_room;
    logic                 emit_req;
    out_word_t            emit_word;
    logic                 admit;
    logic                 slot_ok;
    logic [WIDX_W-1:0]    slot_idx;
    logic                 slot_live;
    logic [WIDX_W-1:0]    rpl_idx;
    logic [WSUM_W-1:0]    wsum;
    logic [WIDX_W-1:0]    win_tail;
    logic [PSUM_W-1:0]    psum;
    logic [PIDX_W-1:0]    pend_tail;
    logic                 pend_full;
    logic                 trim_go;
    logic                 pump_go;
    logic                 dw_hit;
    logic                 dp_hit;
    logic [31:0]          lat;

    logic                 win_we;
    logic [WIDX_W-1:0]    win_waddr;
    logic [WRAM_W-1:0]    win_wdata;
    logic [WIDX_W-1:0]    win_raddr;
    logic [WRAM_W-1:0]    win_rdata;
    logic                 pend_we;
    logic [PRAM_W-1:0]    pend_wdata;
    logic [PIDX_W-1:0]    pend_raddr;
    logic [PRAM_W-1:0]    pend_rdata;

    logic [TAG_WIDTH-1:0] win_rd_tag;
    logic [31:0]          win_rd_start;
    logic                 win_rd_note;
    logic [TAG_WIDTH-1:0] pend_rd_tag;
    logic                 pend_rd_track;
    logic                 pend_rd_notify;

    lara_ram #(
        .WIDTH (WRAM_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_win_ram (
        .clk   (clk),
        .we    (win_we),
        .waddr (win_waddr),
        .wdata (win_wdata),
        .raddr (win_raddr),
        .rdata (win_rdata)
    );

    lara_ram #(
        .WIDTH (PRAM_W),
        .DEPTH (PENDING_DEPTH)
    ) u_pend_ram (
        .clk   (clk),
        .we    (pend_we),
        .waddr (pend_tail),
        .wdata (pend_wdata),
        .raddr (pend_raddr),
        .rdata (pend_rdata)
    );

    lara_admit #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_admit (
        .clk        (clk),
        .cfg        (cfg_reg),
        .min_seen   (min_seen_reg),
        .now        (now_reg),
        .head_start (win_rd_start),
        .win_count  (win_count_reg),
        .admit      (admit)
    );

    assign win_rd_tag     = win_rdata[WRAM_W-1 -: TAG_WIDTH];
    assign win_rd_start   = win_rdata[32:1];
    assign win_rd_note    = win_rdata[0];
    assign pend_rd_tag    = pend_rdata[PRAM_W-1 -: TAG_WIDTH];
    assign pend_rd_track  = pend_rdata[1];
    assign pend_rd_notify = pend_rdata[0];

    assign in_stall  = state_reg != ST_IDLE;
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign res_full  = res_n_reg == MAX_RESULTS;
    assign emit_room = res_full || !hold_valid_reg || out_free;

    assign slot_ok   = {{(32 - SLOT_W){1'b0}}, in_word.slot} < 32'(WINDOW_DEPTH);
    assign slot_idx  = WIDX_W'(in_word.slot);
    assign slot_live = slot_ok && live_reg[slot_idx] && !done_reg[slot_idx];
    assign rpl_idx   = WIDX_W'(in_reg.slot);

    assign wsum      = WSUM_W'(win_head_reg) + WSUM_W'(win_count_reg);
    assign win_tail  = (wsum >= WSUM_W'(WINDOW_DEPTH)) ? WIDX_W'(wsum - WSUM_W'(WINDOW_DEPTH))
                                                       : WIDX_W'(wsum);
    assign psum      = PSUM_W'(pend_head_reg) + PSUM_W'(pend_count_reg);
    assign pend_tail = (psum >= PSUM_W'(PENDING_DEPTH)) ? PIDX_W'(psum - PSUM_W'(PENDING_DEPTH))
                                                        : PIDX_W'(psum);
    assign pend_full = pend_count_reg == PCNT_W'(PENDING_DEPTH);

    assign trim_go = (win_count_reg != '0) && done_reg[win_head_reg];
    assign pump_go = (pend_count_reg != '0) && !res_full && admit;
    assign dw_hit  = live_reg[walk_w_idx_reg] && !done_reg[walk_w_idx_reg] && win_rd_note;
    assign dp_hit  = pend_rd_track;
    assign lat     = now_reg - win_rd_start;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_word.mode == MODE_REQUEST)
                    begin
                        state_next = ST_ADMIT;
                    end
                    else if ((in_word.mode == MODE_REPLY || in_word.mode == MODE_UNDELIVERED)
                             && slot_live)
                    begin
                        state_next = ST_RPL;
                    end
                    else if (in_word.mode == MODE_DISCONNECT)
                    begin
                        state_next = ST_DW_RD;
                    end
                end
            end
            ST_ADMIT:
            begin
                if (emit_room || (!admit && !pend_full))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_RPL:
            begin
                if (emit_room)
                begin
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM:
            begin
                if (!trim_go)
                begin
                    state_next = ST_PUMP;
                end
            end
            ST_PUMP:
            begin
                if (!pump_go)
                begin
                    state_next = ST_FIN;
                end
                else if (emit_room)
                begin
                    state_next = ST_PWAIT;
                end
            end
            ST_PWAIT:
            begin
                state_next = ST_PUMP;
            end
            ST_DW_RD:
            begin
                state_next = (walk_w_left_reg == '0) ? ST_DP_RD : ST_DW;
            end
            ST_DW:
            begin
                if (!dw_hit || emit_room)
                begin
                    state_next = ST_DW_RD;
                end
            end
            ST_DP_RD:
            begin
                state_next = (walk_p_left_reg == '0) ? ST_CLEAR : ST_DP;
            end
            ST_DP:
            begin
                if (!dp_hit || emit_room)
                begin
                    state_next = ST_DP_RD;
                end
            end
            ST_CLEAR:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!hold_valid_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cfg_next         = cfg_reg;
        live_next        = live_reg;
        done_next        = done_reg;
        win_head_next    = win_head_reg;
        win_count_next   = win_count_reg;
        pend_head_next   = pend_head_reg;
        pend_count_next  = pend_count_reg;
        min_seen_next    = min_seen_reg;
        now_next         = now_reg;
        res_n_next       = res_n_reg;
        hold_valid_next  = hold_valid_reg;
        hold_word_next   = hold_word_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_word_next    = out_word_reg;
        in_next          = in_reg;
        walk_w_idx_next  = walk_w_idx_reg;
        walk_w_left_next = walk_w_left_reg;
        walk_p_idx_next  = walk_p_idx_reg;
        walk_p_left_next = walk_p_left_reg;
        emit_req         = 1'b0;
        emit_word        = '0;
        win_we           = 1'b0;
        win_waddr        = win_tail;
        win_wdata        = '0;
        win_raddr        = win_head_reg;
        pend_we          = 1'b0;
        pend_wdata       = '0;
        pend_raddr       = pend_head_reg;

        if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_MIN_IN_FLY:  cfg_next.min_in_fly          = cfg_data[4:0];
                CFG_MAX_IN_FLY:  cfg_next.max_in_fly          = cfg_data[4:0];
                CFG_TARGET_RATE: cfg_next.target_rate         = cfg_data[23:0];
                CFG_MIN_TRACKED: cfg_next.min_tracked_latency = cfg_data[31:0];
                CFG_LAT_FACTOR:  cfg_next.latency_factor      = cfg_data[15:0];
                default:         cfg_next                     = cfg_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    in_next          = in_word;
                    res_n_next       = '0;
                    walk_w_idx_next  = win_head_reg;
                    walk_w_left_next = win_count_reg;
                    walk_p_idx_next  = pend_head_reg;
                    walk_p_left_next = pend_count_reg;
                    if (in_word.mode == MODE_TICK)
                    begin
                        now_next = now_reg + 32'd1;
                    end
                    if ((in_word.mode == MODE_REPLY || in_word.mode == MODE_UNDELIVERED)
                        && slot_ok)
                    begin
                        win_raddr = slot_idx;
                    end
                end
            end
            ST_ADMIT:
            begin
                if (admit)
                begin
                    if (emit_room)
                    begin
                        win_we                = 1'b1;
                        win_wdata             = {TAG_WIDTH'(in_reg.request_tag), now_reg,
                                                 in_reg.session_notify};
                        live_next[win_tail]   = 1'b1;
                        done_next[win_tail]   = 1'b0;
                        win_count_next        = win_count_reg + 1'b1;
                        emit_req              = 1'b1;
                        emit_word.action      = ACT_ISSUE;
                        emit_word.request_tag_res = in_reg.request_tag;
                        emit_word.slot_out    = SLOT_W'(win_tail);
                    end
                end
                else if (pend_full)
                begin
                    if (emit_room)
                    begin
                        emit_req              = 1'b1;
                        emit_word.action      = ACT_DROPPED;
                        emit_word.request_tag_res = in_reg.request_tag;
                    end
                end
                else
                begin
                    pend_we         = 1'b1;
                    pend_wdata      = {TAG_WIDTH'(in_reg.request_tag), in_reg.track_delivery,
                                       in_reg.session_notify};
                    pend_count_next = pend_count_reg + 1'b1;
                end
            end
            ST_RPL:
            begin
                if (emit_room)
                begin
                    emit_req                  = 1'b1;
                    emit_word.action          = (in_reg.mode == MODE_REPLY) ? ACT_REPLY
                                                                            : ACT_UNDELIVERED;
                    emit_word.request_tag_res = TAG_W'(win_rd_tag);
                    done_next[rpl_idx]        = 1'b1;
                    if (in_reg.mode == MODE_REPLY && lat < min_seen_reg)
                    begin
                        min_seen_next = lat;
                    end
                end
            end
            ST_TRIM:
            begin
                if (trim_go)
                begin
                    live_next[win_head_reg] = 1'b0;
                    done_next[win_head_reg] = 1'b0;
                    win_head_next  = (win_head_reg == WIDX_W'(WINDOW_DEPTH - 1)) ? '0
                                                                 : win_head_reg + 1'b1;
                    win_count_next = win_count_reg - 1'b1;
                end
            end
            ST_PUMP:
            begin
                if (pump_go && emit_room)
                begin
                    win_we                = 1'b1;
                    win_wdata             = {pend_rd_tag, now_reg, pend_rd_notify};
                    live_next[win_tail]   = 1'b1;
                    done_next[win_tail]   = 1'b0;
                    win_count_next        = win_count_reg + 1'b1;
                    pend_head_next  = (pend_head_reg == PIDX_W'(PENDING_DEPTH - 1)) ? '0
                                                                 : pend_head_reg + 1'b1;
                    pend_count_next = pend_count_reg - 1'b1;
                    emit_req              = 1'b1;
                    emit_word.action      = ACT_ISSUE;
                    emit_word.request_tag_res = TAG_W'(pend_rd_tag);
                    emit_word.slot_out    = SLOT_W'(win_tail);
                end
            end
            ST_PWAIT:
            begin
                win_raddr = win_head_reg;
            end
            ST_DW_RD:
            begin
                win_raddr = walk_w_idx_reg;
            end
            ST_DW:
            begin
                win_raddr = walk_w_idx_reg;
                if (!dw_hit || emit_room)
                begin
                    emit_req                  = dw_hit;
                    emit_word.action          = ACT_DISCONNECTED;
                    emit_word.request_tag_res = TAG_W'(win_rd_tag);
                    walk_w_idx_next  = (walk_w_idx_reg == WIDX_W'(WINDOW_DEPTH - 1)) ? '0
                                                                 : walk_w_idx_reg + 1'b1;
                    walk_w_left_next = walk_w_left_reg - 1'b1;
                end
            end
            ST_DP_RD:
            begin
                pend_raddr = walk_p_idx_reg;
            end
            ST_DP:
            begin
                pend_raddr = walk_p_idx_reg;
                if (!dp_hit || emit_room)
                begin
                    emit_req                  = dp_hit;
                    emit_word.action          = ACT_DROPPED;
                    emit_word.request_tag_res = TAG_W'(pend_rd_tag);
                    walk_p_idx_next  = (walk_p_idx_reg == PIDX_W'(PENDING_DEPTH - 1)) ? '0
                                                                 : walk_p_idx_reg + 1'b1;
                    walk_p_left_next = walk_p_left_reg - 1'b1;
                end
            end
            ST_CLEAR:
            begin
                live_next       = '0;
                done_next       = '0;
                win_head_next   = '0;
                win_count_next  = '0;
                pend_head_next  = '0;
                pend_count_next = '0;
            end
            ST_FIN:
            begin
                if (hold_valid_reg && out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_word_next        = hold_word_reg;
                    out_word_next.last   = 1'b1;
                    hold_valid_next      = 1'b0;
                end
            end
            default:
            begin
                win_raddr = win_head_reg;
            end
        endcase

        // stage the new word; the one held before it goes out as not last
        if (emit_req && !res_full)
        begin
            res_n_next = res_n_reg + 1'b1;
            if (hold_valid_reg)
            begin
                out_valid_next     = 1'b1;
                out_word_next      = hold_word_reg;
                out_word_next.last = 1'b0;
            end
            hold_valid_next = 1'b1;
            hold_word_next  = emit_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg                   <= ST_IDLE;
            cfg_reg.min_in_fly          <= 5'd0;
            cfg_reg.max_in_fly          <= 5'd16;
            cfg_reg.target_rate         <= 24'd0;
            cfg_reg.min_tracked_latency <= 32'd0;
            cfg_reg.latency_factor      <= 16'd512;
            live_reg                    <= '0;
            done_reg                    <= '0;
            win_head_reg                <= '0;
            win_count_reg               <= '0;
            pend_head_reg               <= '0;
            pend_count_reg              <= '0;
            min_seen_reg                <= MIN_SEEN_RESET;
            now_reg                     <= '0;
            res_n_reg                   <= '0;
            hold_valid_reg              <= 1'b0;
            out_valid_reg               <= 1'b0;
            walk_w_idx_reg              <= '0;
            walk_w_left_reg             <= '0;
            walk_p_idx_reg              <= '0;
            walk_p_left_reg             <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            cfg_reg         <= cfg_next;
            live_reg        <= live_next;
            done_reg        <= done_next;
            win_head_reg    <= win_head_next;
            win_count_reg   <= win_count_next;
            pend_head_reg   <= pend_head_next;
            pend_count_reg  <= pend_count_next;
            min_seen_reg    <= min_seen_next;
            now_reg         <= now_next;
            res_n_reg       <= res_n_next;
            hold_valid_reg  <= hold_valid_next;
            out_valid_reg   <= out_valid_next;
            walk_w_idx_reg  <= walk_w_idx_next;
            walk_w_left_reg <= walk_w_left_next;
            walk_p_idx_reg  <= walk_p_idx_next;
            walk_p_left_reg <= walk_p_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg        <= in_next;
        hold_word_reg <= hold_word_next;
        out_word_reg  <= out_word_next;
    end

    a_win_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        win_count_reg <= WCNT_W'(WINDOW_DEPTH))
        else $error("window count above depth");

    a_pend_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_count_reg <= PCNT_W'(PENDING_DEPTH))
        else $error("pending count above depth");

    a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !hold_valid_reg)
        else $error("staged word left over between input words");

    a_res_limit: assert property (@(posedge clk) disable iff (!rst_n)
        res_n_reg <= MAX_RESULTS)
        else $error("result count above limit");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |=> (win_count_reg == '0 && pend_count_reg == '0
                                     && live_reg == '0))
        else $error("disconnect left entries behind");

endmodule

@@ hw/rtl/lara_ram.sv @@
// Generic simple dual-port RAM with registered read.
module lara_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/lara_admit.sv @@
// Admission decision for the in-flight window: registered products, combinational compares.
module lara_admit #(
    parameter int unsigned WINDOW_DEPTH = 16
) (
    input  logic                                  clk,
    input  lara_pkg::cfg_t                        cfg,
    input  logic [31:0]                           min_seen,
    input  logic [31:0]                           now,
    input  logic [31:0]                           head_start,
    input  logic [$clog2(WINDOW_DEPTH + 1)-1:0]   win_count,
    output logic                                  admit
);

    import lara_pkg::*;

    localparam int unsigned WCNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned NW     = (WCNT_W > 5) ? WCNT_W : 5;

    logic [55:0] cap_prod_reg;
    logic [47:0] age_prod_reg;
    logic [55:0] cap_lim;
    logic [31:0] age;
    logic        full;
    logic        n_le_min;
    logic        n_ge_max;
    logic        cap_hit;
    logic        age_ok;

    always_ff @(posedge clk)
    begin
        cap_prod_reg <= 56'(min_seen) * 56'(cfg.target_rate);
        age_prod_reg <= 48'(min_seen) * 48'(cfg.latency_factor);
    end

    always_comb
    begin
        full     = win_count == WCNT_W'(WINDOW_DEPTH);
        n_le_min = NW'(win_count) <= NW'(cfg.min_in_fly);
        n_ge_max = NW'(win_count) >= NW'(cfg.max_in_fly);
        cap_lim  = (56'(win_count) + 56'd1) * 56'(USEC_PER_SEC);
        cap_hit  = (cfg.target_rate != 24'd0) && (cap_prod_reg >= 56'(USEC_PER_SEC))
                   && (cap_prod_reg < cap_lim);
        age      = now - head_start;
        age_ok   = (age <= cfg.min_tracked_latency) || ({8'd0, age, 8'd0} <= age_prod_reg);
        admit    = !full && (n_le_min || (!n_ge_max && !cap_hit && age_ok));
    end

endmodule

@@ tb/latency_adaptive_request_admission_unit_tb.sv @@
// Testbench for the request admission unit: directed and random words, predicted and checked.
`timescale 1ns / 100ps
module latency_adaptive_request_admission_unit_tb;
    import lara_pkg::*;

    localparam int WIN = 16;
    localparam int PEND = 16;
    localparam int SETTLE = 120;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_word_t in_word;
    logic out_valid;
    logic out_stall;
    out_word_t out_word;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    latency_adaptive_request_admission_unit uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    cfg_t cfg;
    logic [15:0] win_tag [WIN];
    logic [31:0] win_start [WIN];
    logic [2:0] win_flags [WIN];
    int win_head, win_cnt;
    logic [15:0] pend_tag [PEND];
    logic pend_track [PEND];
    logic pend_notify [PEND];
    int pend_head, pend_cnt;
    logic [31:0] min_latency;
    logic [31:0] now_us;

    out_word_t admission_results_q [$];
    out_word_t step_words [$];
    int errors, words_sent, words_checked;
    bit idling, hold_req;

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12ns * 600000);
        $display("Test completed with failures");
        $finish;
    end

    function automatic bit can_admit();
        logic [63:0] cap;
        logic [31:0] age;
        if (win_cnt >= WIN) return 0;
        if (win_cnt <= cfg.min_in_fly) return 1;
        if (win_cnt >= cfg.max_in_fly) return 0;
        if (cfg.target_rate != 0)
        begin
            cap = 64'(min_latency) * 64'(cfg.target_rate) / 64'd1000000;
            if (cap != 0 && 64'(win_cnt) >= cap) return 0;
        end
        age = now_us - win_start[win_head];
        if (age <= cfg.min_tracked_latency) return 1;
        return 64'(age) * 64'd256 <= 64'(min_latency) * 64'(cfg.latency_factor);
    endfunction

    function automatic void emit_word(logic [2:0] act, logic [15:0] tag, logic [3:0] slot);
        out_word_t w;
        if (step_words.size() >= 32) return;
        w.action = act;
        w.request_tag_res = tag;
        w.slot_out = slot;
        w.last = 0;
        step_words.push_back(w);
    endfunction

    function automatic void issue_request(logic [15:0] tag, logic notify);
        int idx;
        idx = (win_head + win_cnt) % WIN;
        win_tag[idx] = tag;
        win_start[idx] = now_us;
        win_flags[idx] = {notify, 2'b01};
        win_cnt++;
        emit_word(ACT_ISSUE, tag, 4'(idx));
    endfunction

    function automatic void admit_step(in_word_t w);
        logic [31:0] lat;
        int idx;
        step_words.delete();
        case (w.mode)
            MODE_REQUEST:
                if (can_admit()) issue_request(w.request_tag, w.session_notify);
                else if (pend_cnt >= PEND) emit_word(ACT_DROPPED, w.request_tag, 0);
                else
                begin
                    idx = (pend_head + pend_cnt) % PEND;
                    pend_tag[idx] = w.request_tag;
                    pend_track[idx] = w.track_delivery;
                    pend_notify[idx] = w.session_notify;
                    pend_cnt++;
                end
            MODE_REPLY, MODE_UNDELIVERED:
                if (win_flags[w.slot][0] && !win_flags[w.slot][1])
                begin
                    emit_word(w.mode, win_tag[w.slot], 0);
                    if (w.mode == MODE_REPLY)
                    begin
                        lat = now_us - win_start[w.slot];
                        if (lat < min_latency) min_latency = lat;
                    end
                    win_flags[w.slot][1] = 1;
                    while (win_cnt != 0 && win_flags[win_head][1])
                    begin
                        win_flags[win_head] = 0;
                        win_head = (win_head + 1) % WIN;
                        win_cnt--;
                    end
                    while (pend_cnt != 0 && step_words.size() < 32 && can_admit())
                    begin
                        idx = pend_head;
                        pend_head = (pend_head + 1) % PEND;
                        pend_cnt--;
                        issue_request(pend_tag[idx], pend_notify[idx]);
                    end
                end
            MODE_DISCONNECT:
            begin
                for (int i = 0; i < win_cnt; i++)
                begin
                    idx = (win_head + i) % WIN;
                    if (win_flags[idx] == 3'b101) emit_word(ACT_DISCONNECTED, win_tag[idx], 0);
                end
                for (int i = 0; i < pend_cnt; i++)
                begin
                    idx = (pend_head + i) % PEND;
                    if (pend_track[idx]) emit_word(ACT_DROPPED, pend_tag[idx], 0);
                end
                for (int i = 0; i < WIN; i++) win_flags[i] = 0;
                win_head = 0;
                win_cnt = 0;
                pend_head = 0;
                pend_cnt = 0;
            end
            MODE_TICK: now_us++;
            default: ;
        endcase
        if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1;
        foreach (step_words[i]) admission_results_q.push_back(step_words[i]);
    endfunction

    task automatic send_word(in_word_t w);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1;
        in_word <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        admit_step(w);
        words_sent++;
    endtask

    task automatic send_fields(logic [2:0] mode, logic [15:0] tag, logic [3:0] slot,
                               logic track, logic notify);
        in_word_t w;
        w.mode = mode;
        w.request_tag = tag;
        w.slot = slot;
        w.track_delivery = track;
        w.session_notify = notify;
        send_word(w);
    endtask

    task automatic wait_idle();
        in_valid <= 0;
        while (admission_results_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            CFG_MIN_IN_FLY: cfg.min_in_fly = data[4:0];
            CFG_MAX_IN_FLY: cfg.max_in_fly = data[4:0];
            CFG_TARGET_RATE: cfg.target_rate = data[23:0];
            CFG_MIN_TRACKED: cfg.min_tracked_latency = data;
            default: cfg.latency_factor = data[15:0];
        endcase
    endtask

    task automatic set_cfg(int mn, int mx, int rate, logic [31:0] tracked, int factor);
        wait_idle();
        write_cfg(CFG_MIN_IN_FLY, mn);
        write_cfg(CFG_MAX_IN_FLY, mx);
        write_cfg(CFG_TARGET_RATE, rate);
        write_cfg(CFG_MIN_TRACKED, tracked);
        write_cfg(CFG_LAT_FACTOR, factor);
        cfg_we <= 0;
    endtask

    task automatic send_random();
        int r, live [$];
        logic [3:0] slot;
        for (int i = 0; i < WIN; i++)
            if (win_flags[i][1:0] == 2'b01) live.push_back(i);
        slot = live.size() ? 4'(live[$urandom_range(0, live.size() - 1)]) : 4'($urandom);
        r = $urandom_range(0, 99);
        if (r < 42)
            send_fields(MODE_REQUEST, $urandom, $urandom, $urandom, $urandom);
        else if (r < 67)
            send_fields(MODE_REPLY, $urandom, slot, $urandom, $urandom);
        else if (r < 75)
            send_fields(MODE_UNDELIVERED, $urandom, slot, $urandom, $urandom);
        else if (r < 79)
            send_fields($urandom_range(1, 2), $urandom, $urandom, $urandom, $urandom);
        else if (r < 95)
            send_fields(MODE_TICK, $urandom, $urandom, $urandom, $urandom);
        else if (r < 98)
            send_fields(MODE_DISCONNECT, $urandom, $urandom, $urandom, $urandom);
        else
            send_fields($urandom_range(5, 7), $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic test_directed();
        send_fields(MODE_REQUEST, 16'h0000, 0, 0, 0);
        send_fields(MODE_REQUEST, 16'hFFFF, 4'hF, 1, 1);
        send_fields(MODE_REQUEST, 16'h5A5A, 0, 1, 0);
        send_fields(MODE_TICK, 0, 0, 0, 0);
        send_fields(MODE_TICK, 16'hFFFF, 4'hF, 1, 1);
        send_fields(MODE_REPLY, 0, 1, 0, 0);
        send_fields(MODE_REPLY, 0, 1, 0, 0);
        send_fields(MODE_UNDELIVERED, 0, 0, 0, 0);
        send_fields(MODE_UNDELIVERED, 0, 4'hF, 0, 0);
        send_fields(3'd5, 16'h1234, 2, 1, 1);
        send_fields(3'd6, 0, 0, 0, 0);
        send_fields(3'd7, 16'hFFFF, 4'hF, 1, 1);
        send_fields(MODE_REQUEST, 16'hA5A5, 0, 0, 1);
        send_fields(MODE_DISCONNECT, 0, 0, 0, 0);
        send_fields(MODE_DISCONNECT, 0, 0, 0, 0);
    endtask

    task automatic test_disconnect_mix();
        set_cfg(0, 2, 0, 0, 512);
        for (int i = 0; i < 6; i++)
            send_fields(MODE_REQUEST, 16'(16'h0100 + i), 0, i[0], i[1]);
        send_fields(MODE_REPLY, 0, 0, 0, 0);
        send_fields(MODE_DISCONNECT, 0, 0, 0, 0);
    endtask

    task automatic test_pressure();
        set_cfg(0, 16, 0, 32'hFFFF_FFFF, 512);
        hold_req = 1;
        for (int i = 0; i < 40; i++)
            send_fields(MODE_REQUEST, $urandom, 0, $urandom, $urandom);
        send_fields(MODE_DISCONNECT, 0, 0, 0, 0);
    endtask

    task automatic test_pause();
        for (int i = 0; i < 20; i++) send_random();
        wait_idle();
        for (int i = 0; i < 10; i++) send_random();
    endtask

    task automatic test_random_phases();
        set_cfg(16, 16, 0, 0, 0);
        repeat (50) send_random();
        set_cfg(0, 0, 16777215, 0, 65535);
        repeat (40) send_random();
        set_cfg(2, 12, 16777215, 3, 0);
        repeat (60) send_random();
        set_cfg(1, 16, 4, 0, 256);
        repeat (50) send_random();
        for (int p = 0; p < 3; p++)
        begin
            set_cfg($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 40),
                    $urandom_range(0, 6), $urandom_range(0, 1024));
            repeat (40) send_random();
        end
        set_cfg(4, 16, 16777215, 32'hFFFF_FFFF, 65535);
        idling = 0;
        repeat (60) send_random();
    endtask

    initial
    begin
        out_word_t exp;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                words_checked++;
                if (admission_results_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word, actual %h", $time, out_word);
                end
                else
                begin
                    exp = admission_results_q[0];
                    admission_results_q.delete(0);
                    if (exp.action !== out_word.action ||
                        exp.request_tag_res !== out_word.request_tag_res ||
                        exp.slot_out !== out_word.slot_out || exp.last !== out_word.last)
                    begin
                        errors++;
                        $display("%0t: mismatch action %0d/%0d tag %h/%h slot %0d/%0d last %0d/%0d",
                                 $time, exp.action, out_word.action, exp.request_tag_res,
                                 out_word.request_tag_res, exp.slot_out, out_word.slot_out,
                                 exp.last, out_word.last);
                    end
                end
            end
        end
    end

    initial
    begin
        out_stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1;
                repeat (300) @(posedge clk);
                hold_req = 0;
                out_stall <= 0;
            end
            else if (idling && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                out_stall <= 0;
            end
            else
                out_stall <= 0;
        end
    end

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        in_word = '0;
        cfg_we = 0;
        cfg_idx = '0;
        cfg_data = '0;
        errors = 0;
        words_sent = 0;
        words_checked = 0;
        idling = 1;
        hold_req = 0;
        cfg.min_in_fly = 0;
        cfg.max_in_fly = 16;
        cfg.target_rate = 0;
        cfg.min_tracked_latency = 0;
        cfg.latency_factor = 512;
        for (int i = 0; i < WIN; i++) win_flags[i] = 0;
        win_head = 0;
        win_cnt = 0;
        pend_head = 0;
        pend_cnt = 0;
        min_latency = MIN_SEEN_RESET;
        now_us = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_directed();
        test_disconnect_mix();
        test_pressure();
        test_pause();
        test_random_phases();
        wait_idle();
        $display("Run covered %0d input words and %0d result words over ten register settings,",
                 words_sent, words_checked);
        $display("including a full pending queue, drops, disconnects and long output stalls.");
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
